// File: hdl/accel_average_tilt_angles_core_defines.svh
// Assertion macros for the accelerometer tilt angle core.
`ifndef ACCEL_AVERAGE_TILT_ANGLES_CORE_DEFINES_SVH
`define ACCEL_AVERAGE_TILT_ANGLES_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define AATC_CHECK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aatc check failed");

// Check that a condition implies another in the next cycle.
`define AATC_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aatc check failed");

`endif

// File: hdl/aatc_pkg.sv
// Shared types, constants and the arctangent table of the tilt angle core.
package aatc_pkg;

    localparam int BLOCK_SAMPLES_DEF    = 16;
    localparam int ANGLE_ITERATIONS_DEF = 16;

    localparam int SAMPLE_W = 20;
    localparam int TOTAL_W  = 28;
    localparam int COUNT_W  = 9;
    localparam int TILT_W   = 15;
    localparam int ROOT_W   = 32;
    localparam int CORD_W   = 56;
    localparam int ANGLE_W  = 32;
    localparam int TABLE_LEN = 24;
    localparam int ITER_W   = 5;
    localparam int DIV_W    = TOTAL_W + 1;
    localparam int SQRT_STEPS = 32;
    localparam int TILT_LIMIT = 9000;

    // atan(2^-i) in 1/65536 of a hundredth of a degree
    localparam logic [29:0] ATAN_TABLE [TABLE_LEN] = '{
        30'd294912000, 30'd174096719, 30'd91987925, 30'd46694507,
        30'd23437865,  30'd11730358,  30'd5866610,  30'd2933484,
        30'd1466764,   30'd733385,    30'd366693,   30'd183346,
        30'd91673,     30'd45837,     30'd22918,    30'd11459,
        30'd5730,      30'd2865,      30'd1432,     30'd716,
        30'd358,       30'd179,       30'd90,       30'd45
    };

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MULP  = 9'b000000010,
        ST_MULQ  = 9'b000000100,
        ST_ADD   = 9'b000001000,
        ST_SQRT  = 9'b000010000,
        ST_CLOAD = 9'b000100000,
        ST_CORD  = 9'b001000000,
        ST_ROUND = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    typedef struct packed {
        logic              accept;
        logic              mul_p;
        logic              mul_q;
        logic              sum_load;
        logic              sqrt_step;
        logic              div_step;
        logic              cordic_load;
        logic              cordic_step;
        logic              round;
        logic              out_load;
        logic              sel;
        logic [ITER_W-1:0] iter;
    } cmd_t;

    typedef struct packed {
        logic last_sample;
    } status_t;

endpackage

// File: hdl/accel_average_tilt_angles_core.sv
// Top level of the accelerometer block averager with tilt angles.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  in      | sink      | in_valid / in_ready | x_sample, y_sample, z_sample
//  out     | source    | out_valid/out_ready | x_mean, y_mean, z_mean, tilt_x/y
//
// A sample that does not close a block is only added to the totals. The closing
// sample starts two angle passes (squares on one multiplier, bit-serial square
// root, CORDIC loop, rounding), then the output load step; no input is taken
// until the output is loaded.
// The output register lets input resume while a result waits; a stalled result
// holds the next one in the output load step. Reset clears totals and count.
`include "accel_average_tilt_angles_core_defines.svh"

module accel_average_tilt_angles_core
    import aatc_pkg::*;
#(
    parameter int BLOCK_SAMPLES    = BLOCK_SAMPLES_DEF,
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] x_sample,
    input  logic signed [SAMPLE_W-1:0] y_sample,
    input  logic signed [SAMPLE_W-1:0] z_sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] x_mean,
    output logic signed [SAMPLE_W-1:0] y_mean,
    output logic signed [SAMPLE_W-1:0] z_mean,
    output logic signed [TILT_W-1:0]   tilt_x,
    output logic signed [TILT_W-1:0]   tilt_y
);

    cmd_t    cmd;
    status_t status;

    aatc_ctrl #(
        .ANGLE_ITERATIONS(ANGLE_ITERATIONS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status),
        .cmd      (cmd)
    );

    aatc_datapath #(
        .BLOCK_SAMPLES(BLOCK_SAMPLES)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .x_sample(x_sample),
        .y_sample(y_sample),
        .z_sample(z_sample),
        .x_mean  (x_mean),
        .y_mean  (y_mean),
        .z_mean  (z_mean),
        .tilt_x  (tilt_x),
        .tilt_y  (tilt_y)
    );

    // Closing transfer of a block starts the angle passes
    `AATC_CHECK_NEXT(a_block_end_busy, in_valid && in_ready && status.last_sample, !in_ready)
    // Angles stay within a quarter turn
    `AATC_CHECK_SAME(a_tilt_x_range, out_valid, tilt_x <= 15'sd9000 && tilt_x >= -15'sd9000)
    `AATC_CHECK_SAME(a_tilt_y_range, out_valid, tilt_y <= 15'sd9000 && tilt_y >= -15'sd9000)

endmodule

// File: hdl/aatc_ctrl.sv
// Sequencer of the tilt angle core: handshakes, step counter and state.
module aatc_ctrl
    import aatc_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITERATIONS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [ITER_W-1:0] SQRT_LAST = ITER_W'(SQRT_STEPS - 1);
    localparam logic [ITER_W-1:0] CORD_LAST = ITER_W'(ANGLE_ITERATIONS - 1);
    localparam logic [ITER_W-1:0] DIV_STEPS = ITER_W'(3);

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              sel_reg, sel_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Advance the sequence
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.sel        = sel_reg;
        cmd.iter       = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.last_sample)
                    begin
                        sel_next   = 1'b0;
                        state_next = ST_MULP;
                    end
                end
            end
            ST_MULP:
            begin
                cmd.mul_p  = 1'b1;
                state_next = ST_MULQ;
            end
            ST_MULQ:
            begin
                cmd.mul_q  = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.sum_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cmd.div_step  = (cnt_reg < DIV_STEPS);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_LAST)
                begin
                    state_next = ST_CLOAD;
                end
            end
            ST_CLOAD:
            begin
                cmd.cordic_load = 1'b1;
                cnt_next        = '0;
                state_next      = ST_CORD;
            end
            ST_CORD:
            begin
                cmd.cordic_step = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == CORD_LAST)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (sel_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    sel_next   = 1'b1;
                    state_next = ST_MULP;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hdl/aatc_datapath.sv
// Accumulators, mean dividers, square root and CORDIC of the tilt angle core.
module aatc_datapath
    import aatc_pkg::*;
#(
    parameter int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    output status_t                    status,
    input  logic signed [SAMPLE_W-1:0] x_sample,
    input  logic signed [SAMPLE_W-1:0] y_sample,
    input  logic signed [SAMPLE_W-1:0] z_sample,
    output logic signed [SAMPLE_W-1:0] x_mean,
    output logic signed [SAMPLE_W-1:0] y_mean,
    output logic signed [SAMPLE_W-1:0] z_mean,
    output logic signed [TILT_W-1:0]   tilt_x,
    output logic signed [TILT_W-1:0]   tilt_y
);

    // reciprocal of the block length: exact floor quotient for dividends below 2^TOTAL_W
    localparam int                 DIV_L   = $clog2(BLOCK_SAMPLES);
    localparam int                 DIV_SH  = TOTAL_W + DIV_L;
    localparam logic [63:0]        DIV_ONE = 64'(1) << DIV_SH;
    localparam logic [DIV_W-1:0]   DIV_MUL =
        DIV_W'((DIV_ONE + 64'(BLOCK_SAMPLES - 1)) / 64'(BLOCK_SAMPLES));
    localparam logic [DIV_W-1:0]   NM1  = DIV_W'(BLOCK_SAMPLES - 1);
    localparam logic [COUNT_W-1:0] CLAST = COUNT_W'(BLOCK_SAMPLES - 1);

    // running totals and captured block totals (x, y, z)
    logic signed [TOTAL_W-1:0] tot_reg [3];
    logic signed [TOTAL_W-1:0] blk_reg [3];
    logic [COUNT_W-1:0]        count_reg;
    logic signed [SAMPLE_W-1:0] smp [3];

    // dividers
    logic [DIV_W-1:0]    div_a_reg [3];
    logic                div_neg_reg [3];
    logic [SAMPLE_W-1:0] quo_reg [3];
    logic [DIV_W-1:0]    div_op;
    logic [2*DIV_W-1:0]  div_prod;
    logic [SAMPLE_W-1:0] div_quo;

    // squares and root
    logic [TOTAL_W-1:0]   mul_op;
    logic [2*TOTAL_W-1:0] prod_reg, acc_reg;
    logic [2*TOTAL_W:0]   sq_sum;
    logic [63:0]          sv_reg, sres_reg, sbit_reg, strial;

    // CORDIC
    logic signed [TOTAL_W-1:0] num_sel, p_sel, q_sel;
    logic signed [CORD_W-1:0]  cx_reg, cy_reg, dx, dy;
    logic signed [ANGLE_W-1:0] cz_reg, tab, zr;
    logic                      zero_reg;
    logic signed [TILT_W-1:0]  tilt_val;
    logic signed [TILT_W-1:0]  tx_reg, ty_reg;
    logic signed [TILT_W-1:0]  txo_reg, tyo_reg;

    logic signed [SAMPLE_W-1:0] mean_val [3];
    logic signed [SAMPLE_W-1:0] xm_reg, ym_reg, zm_reg;

    assign smp[0] = x_sample;
    assign smp[1] = y_sample;
    assign smp[2] = z_sample;

    assign status.last_sample = (count_reg == CLAST);

    // Accumulate samples and count the block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                tot_reg[a] <= '0;
            end
            count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (status.last_sample)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    tot_reg[a] <= '0;
                end
                count_reg <= '0;
            end
            else
            begin
                for (int a = 0; a < 3; a++)
                begin
                    tot_reg[a] <= tot_reg[a] + TOTAL_W'(smp[a]);
                end
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Capture the finished block totals
    always_ff @(posedge clk)
    begin
        if (cmd.accept && status.last_sample)
        begin
            for (int a = 0; a < 3; a++)
            begin
                blk_reg[a] <= tot_reg[a] + TOTAL_W'(smp[a]);
            end
        end
    end

    // Pick the magnitude of one axis for the shared reciprocal product
    always_comb
    begin
        case (cmd.iter)
            ITER_W'(1): div_op = div_a_reg[1];
            ITER_W'(2): div_op = div_a_reg[2];
            default:    div_op = div_a_reg[0];
        endcase
    end

    assign div_prod = div_op * DIV_MUL;
    assign div_quo  = div_prod[DIV_SH +: SAMPLE_W];

    // Divide each total by the block length, one axis a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.sum_load)
        begin
            for (int a = 0; a < 3; a++)
            begin
                div_neg_reg[a] <= blk_reg[a][TOTAL_W-1];
                div_a_reg[a]   <= blk_reg[a][TOTAL_W-1] ? (NM1 - DIV_W'(blk_reg[a]))
                                                        : DIV_W'(blk_reg[a]);
            end
        end
        else if (cmd.div_step)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (cmd.iter == ITER_W'(a))
                begin
                    quo_reg[a] <= div_quo;
                end
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            mean_val[a] = div_neg_reg[a] ? SAMPLE_W'(-quo_reg[a])
                                         : SAMPLE_W'(quo_reg[a]);
        end
    end

    // Select operands for the current angle
    assign num_sel = cmd.sel ? blk_reg[1] : blk_reg[0];
    assign p_sel   = cmd.sel ? blk_reg[0] : blk_reg[1];
    assign q_sel   = blk_reg[2];

    // Square one magnitude a cycle
    always_comb
    begin
        logic signed [TOTAL_W-1:0] op;
        op     = cmd.mul_q ? q_sel : p_sel;
        mul_op = op[TOTAL_W-1] ? TOTAL_W'(-op) : TOTAL_W'(op);
    end

    assign sq_sum = {1'b0, acc_reg} + {1'b0, prod_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.mul_p || cmd.mul_q)
        begin
            prod_reg <= mul_op * mul_op;
        end
        if (cmd.mul_q)
        begin
            acc_reg <= prod_reg;
        end
    end

    // Take the floor square root, one result bit a cycle
    assign strial = sres_reg + sbit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sum_load)
        begin
            sv_reg   <= 64'(sq_sum) << 8;
            sres_reg <= '0;
            sbit_reg <= 64'(1) << 62;
        end
        else if (cmd.sqrt_step)
        begin
            if (sv_reg >= strial)
            begin
                sv_reg   <= sv_reg - strial;
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end
            else
            begin
                sres_reg <= sres_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
    end

    // Rotate toward zero, one step a cycle
    assign dx  = cy_reg >>> cmd.iter;
    assign dy  = cx_reg >>> cmd.iter;
    assign tab = ANGLE_W'(ATAN_TABLE[cmd.iter]);

    always_ff @(posedge clk)
    begin
        if (cmd.cordic_load)
        begin
            cx_reg   <= CORD_W'({sres_reg[ROOT_W-1:0], 20'b0});
            cy_reg   <= CORD_W'(num_sel) <<< 24;
            cz_reg   <= '0;
            zero_reg <= (num_sel == '0) && (sres_reg[ROOT_W-1:0] == '0);
        end
        else if (cmd.cordic_step)
        begin
            if (!cy_reg[CORD_W-1])
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + tab;
            end
            else
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - tab;
            end
        end
    end

    // Round to the nearest hundredth and clamp; a zero vector gives zero
    always_comb
    begin
        zr = (cz_reg + ANGLE_W'(32768)) >>> 16;
        if (zero_reg)
        begin
            tilt_val = '0;
        end
        else if (zr > ANGLE_W'(TILT_LIMIT))
        begin
            tilt_val = TILT_W'(TILT_LIMIT);
        end
        else if (zr < -ANGLE_W'(TILT_LIMIT))
        begin
            tilt_val = -TILT_W'(TILT_LIMIT);
        end
        else
        begin
            tilt_val = TILT_W'(zr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.round)
        begin
            if (cmd.sel)
            begin
                ty_reg <= tilt_val;
            end
            else
            begin
                tx_reg <= tilt_val;
            end
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            xm_reg  <= mean_val[0];
            ym_reg  <= mean_val[1];
            zm_reg  <= mean_val[2];
            txo_reg <= tx_reg;
            tyo_reg <= ty_reg;
        end
    end

    assign x_mean = xm_reg;
    assign y_mean = ym_reg;
    assign z_mean = zm_reg;
    assign tilt_x = txo_reg;
    assign tilt_y = tyo_reg;

endmodule
